[design/gaussian_covariance_from_scale_rot_defines.svh]
`ifndef GAUSSIAN_COVARIANCE_FROM_SCALE_ROT_DEFINES_SVH
`define GAUSSIAN_COVARIANCE_FROM_SCALE_ROT_DEFINES_SVH

// same-cycle implication
`define GCOV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcov check failed: same-cycle rule");

// next-cycle implication
`define GCOV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcov check failed: next-cycle rule");

`endif

[design/gcov_pkg.sv]
package gcov_pkg;

    localparam int SCALE_W    = 32;
    localparam int QUAT_W     = 16;
    localparam int MOD_W      = 24;
    localparam int COV_W      = 64;
    localparam int NUM_AXES   = 3;
    localparam int NUM_COV    = 6;

    localparam logic [MOD_W-1:0] MOD_RESET = 24'd65536;

    // scaled axis, its square and the split used for squaring
    localparam int S_W        = SCALE_W + MOD_W;
    localparam int HALF_W     = S_W / 2;
    localparam int SQ_W       = 2 * S_W;

    // rotation entries, Q.28
    localparam int QP_W       = 2 * QUAT_W;
    localparam int ROT_W      = QP_W + 2;
    localparam int FRAC_R     = 28;
    localparam logic signed [ROT_W:0] ROT_ONE = 1 << FRAC_R;

    // product of two rotation entries and its split for the wide multiply
    localparam int PROD_W     = 2 * ROT_W - 1;
    localparam int PLO_W      = 32;
    localparam int PHI_W      = PROD_W - PLO_W;
    localparam int PIECE_W    = 28;
    localparam int NUM_PIECES = SQ_W / PIECE_W;

    // one term, the three-term sum and the output window
    localparam int TERM_W     = 178;
    localparam int ACC_W      = 180;
    localparam int OUT_SHIFT  = 88;

    localparam logic signed [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic signed [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};

    localparam int COV_ROW [NUM_COV] = '{0, 0, 0, 1, 1, 2};
    localparam int COV_COL [NUM_COV] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic mul;
        logic pair;
        logic row;
        logic fin;
    } term_en_t;

endpackage

[design/gcov_term.sv]
module gcov_term
    import gcov_pkg::*;
(
    input  logic                     clk,
    input  term_en_t                 en,
    input  logic signed [PROD_W-1:0] prod,
    input  logic        [SQ_W-1:0]   sq,
    output logic signed [TERM_W-1:0] term
);

    localparam int LO_PP_W   = PLO_W + PIECE_W;
    localparam int HI_PP_W   = PHI_W + PIECE_W + 1;
    localparam int LO_PAIR_W = LO_PP_W + PIECE_W + 1;
    localparam int HI_PAIR_W = HI_PP_W + PIECE_W;
    localparam int LO_ROW_W  = LO_PAIR_W + 2 * PIECE_W + 1;
    localparam int HI_ROW_W  = HI_PAIR_W + 2 * PIECE_W + 1;

    logic        [LO_PP_W-1:0]   pl_reg [NUM_PIECES];
    logic        [LO_PP_W-1:0]   pl_next [NUM_PIECES];
    logic signed [HI_PP_W-1:0]   ph_reg [NUM_PIECES];
    logic signed [HI_PP_W-1:0]   ph_next [NUM_PIECES];
    logic        [LO_PAIR_W-1:0] al_reg [2];
    logic        [LO_PAIR_W-1:0] al_next [2];
    logic signed [HI_PAIR_W-1:0] ah_reg [2];
    logic signed [HI_PAIR_W-1:0] ah_next [2];
    logic        [LO_ROW_W-1:0]  rl_reg;
    logic        [LO_ROW_W-1:0]  rl_next;
    logic signed [HI_ROW_W-1:0]  rh_reg;
    logic signed [HI_ROW_W-1:0]  rh_next;
    logic signed [TERM_W-1:0]    term_reg;
    logic signed [TERM_W-1:0]    term_next;

    // partial products: low and high half of prod against each 28-bit piece of sq
    always_comb
    begin
        for (int b = 0; b < NUM_PIECES; b++)
        begin
            pl_next[b] = LO_PP_W'(prod[PLO_W-1:0]) * LO_PP_W'(sq[b*PIECE_W +: PIECE_W]);
            ph_next[b] = HI_PP_W'($signed(prod[PROD_W-1:PLO_W]))
                       * HI_PP_W'($signed({1'b0, sq[b*PIECE_W +: PIECE_W]}));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            al_next[k] = LO_PAIR_W'(pl_reg[2*k])
                       + (LO_PAIR_W'(pl_reg[2*k+1]) << PIECE_W);
            ah_next[k] = HI_PAIR_W'(ph_reg[2*k])
                       + (HI_PAIR_W'(ph_reg[2*k+1]) <<< PIECE_W);
        end
        rl_next   = LO_ROW_W'(al_reg[0]) + (LO_ROW_W'(al_reg[1]) << (2 * PIECE_W));
        rh_next   = HI_ROW_W'(ah_reg[0]) + (HI_ROW_W'(ah_reg[1]) <<< (2 * PIECE_W));
        term_next = (TERM_W'(rh_reg) <<< PLO_W) + TERM_W'($signed({1'b0, rl_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
        if (en.pair)
        begin
            al_reg <= al_next;
            ah_reg <= ah_next;
        end
        if (en.row)
        begin
            rl_reg <= rl_next;
            rh_reg <= rh_next;
        end
        if (en.fin)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

[design/gaussian_covariance_from_scale_rot.sv]
// path: an accepted input word reaches out_valid through stages 0 to 9 in order
// throughput: one word per cycle; each stage moves when its successor has room,
// so bubbles close up and a stalled output word keeps the stages behind it filled
// reset: valid bits of all 10 stages clear, scale_modifier loads 1.0 (Q8.16)
module gaussian_covariance_from_scale_rot
    import gcov_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [MOD_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SCALE_W-1:0]      scale_x,
    input  logic [SCALE_W-1:0]      scale_y,
    input  logic [SCALE_W-1:0]      scale_z,
    input  logic signed [QUAT_W-1:0] quat_r,
    input  logic signed [QUAT_W-1:0] quat_i,
    input  logic signed [QUAT_W-1:0] quat_j,
    input  logic signed [QUAT_W-1:0] quat_k,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [COV_W-1:0] cov_xx,
    output logic signed [COV_W-1:0] cov_xy,
    output logic signed [COV_W-1:0] cov_xz,
    output logic signed [COV_W-1:0] cov_yy,
    output logic signed [COV_W-1:0] cov_yz,
    output logic signed [COV_W-1:0] cov_zz
);

    localparam int NUM_STAGES = 10;
    localparam int ST_MUL     = 3;
    localparam int ST_PAIR    = 4;
    localparam int ST_ROW     = 5;
    localparam int ST_TERM    = 6;
    localparam int ST_SUM     = 7;
    localparam int ST_ACC     = 8;
    localparam int ST_OUT     = 9;

    function automatic logic signed [ROT_W-1:0] rot_diag(
        input logic signed [QP_W-1:0] a,
        input logic signed [QP_W-1:0] b
    );
        logic signed [ROT_W:0] v;
        v = ROT_ONE - (((ROT_W+1)'(a) + (ROT_W+1)'(b)) <<< 1);
        return v[ROT_W-1:0];
    endfunction

    function automatic logic signed [ROT_W-1:0] rot_sum(
        input logic signed [QP_W-1:0] a,
        input logic signed [QP_W-1:0] b
    );
        logic signed [ROT_W:0] v;
        v = ((ROT_W+1)'(a) + (ROT_W+1)'(b)) <<< 1;
        return v[ROT_W-1:0];
    endfunction

    function automatic logic signed [ROT_W-1:0] rot_diff(
        input logic signed [QP_W-1:0] a,
        input logic signed [QP_W-1:0] b
    );
        logic signed [ROT_W:0] v;
        v = ((ROT_W+1)'(a) - (ROT_W+1)'(b)) <<< 1;
        return v[ROT_W-1:0];
    endfunction

    function automatic logic signed [COV_W-1:0] sat_q32(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-OUT_SHIFT-COV_W:0] top_bits;
        logic signed [COV_W-1:0]        res;
        top_bits = a[ACC_W-1:OUT_SHIFT+COV_W-1];
        priority if (&top_bits || ~|top_bits)
        begin
            res = a[OUT_SHIFT+COV_W-1:OUT_SHIFT];
        end
        else if (a[ACC_W-1])
        begin
            res = COV_MIN;
        end
        else
        begin
            res = COV_MAX;
        end
        return res;
    endfunction

    // control
    logic [MOD_W-1:0]      mod_reg;
    logic [MOD_W-1:0]      mod_next;
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] stage_en;
    term_en_t              term_en;

    // stage 0: scaled axes and quaternion products
    logic        [S_W-1:0]  s_reg [NUM_AXES];
    logic        [S_W-1:0]  s_next [NUM_AXES];
    logic signed [QP_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [QP_W-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [QP_W-1:0] xx_next, yy_next, zz_next, xy_next, xz_next, yz_next;
    logic signed [QP_W-1:0] rx_next, ry_next, rz_next;

    // stage 1: square pieces and rotation matrix
    logic        [S_W-1:0]   hh_reg [NUM_AXES];
    logic        [S_W-1:0]   hl_reg [NUM_AXES];
    logic        [S_W-1:0]   ll_reg [NUM_AXES];
    logic        [S_W-1:0]   hh_next [NUM_AXES];
    logic        [S_W-1:0]   hl_next [NUM_AXES];
    logic        [S_W-1:0]   ll_next [NUM_AXES];
    logic signed [ROT_W-1:0] rot_reg [NUM_AXES*NUM_AXES];
    logic signed [ROT_W-1:0] rot_next [NUM_AXES*NUM_AXES];

    // stage 2: squared scales and rotation products
    logic        [SQ_W-1:0]   sq_reg [NUM_AXES];
    logic        [SQ_W-1:0]   sq_next [NUM_AXES];
    logic signed [PROD_W-1:0] prod_reg [NUM_COV][NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_COV][NUM_AXES];

    // stages 3 to 6 inside the term units
    logic signed [TERM_W-1:0] term_w [NUM_COV][NUM_AXES];

    // stages 7 to 9: sum and saturate
    logic signed [ACC_W-1:0]  sum01_reg [NUM_COV];
    logic signed [ACC_W-1:0]  sum01_next [NUM_COV];
    logic signed [TERM_W-1:0] t2_reg [NUM_COV];
    logic signed [TERM_W-1:0] t2_next [NUM_COV];
    logic signed [ACC_W-1:0]  acc_reg [NUM_COV];
    logic signed [ACC_W-1:0]  acc_next [NUM_COV];
    logic signed [COV_W-1:0]  cov_reg [NUM_COV];
    logic signed [COV_W-1:0]  cov_next [NUM_COV];

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        stage_en[ST_OUT] = !v_reg[ST_OUT] || !out_stall;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            stage_en[k] = !v_reg[k] || stage_en[k+1];
        end
        v_next[0] = stage_en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = stage_en[k] ? v_reg[k-1] : v_reg[k];
        end
        mod_next     = cfg_wr_en ? cfg_wr_data : mod_reg;
        term_en.mul  = stage_en[ST_MUL];
        term_en.pair = stage_en[ST_PAIR];
        term_en.row  = stage_en[ST_ROW];
        term_en.fin  = stage_en[ST_TERM];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            mod_reg <= MOD_RESET;
        end
        else
        begin
            v_reg   <= v_next;
            mod_reg <= mod_next;
        end
    end

    always_comb
    begin
        s_next[0] = S_W'(scale_x) * S_W'(mod_reg);
        s_next[1] = S_W'(scale_y) * S_W'(mod_reg);
        s_next[2] = S_W'(scale_z) * S_W'(mod_reg);
        xx_next   = QP_W'(quat_i) * QP_W'(quat_i);
        yy_next   = QP_W'(quat_j) * QP_W'(quat_j);
        zz_next   = QP_W'(quat_k) * QP_W'(quat_k);
        xy_next   = QP_W'(quat_i) * QP_W'(quat_j);
        xz_next   = QP_W'(quat_i) * QP_W'(quat_k);
        yz_next   = QP_W'(quat_j) * QP_W'(quat_k);
        rx_next   = QP_W'(quat_r) * QP_W'(quat_i);
        ry_next   = QP_W'(quat_r) * QP_W'(quat_j);
        rz_next   = QP_W'(quat_r) * QP_W'(quat_k);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            hh_next[i] = S_W'(s_reg[i][S_W-1:HALF_W]) * S_W'(s_reg[i][S_W-1:HALF_W]);
            hl_next[i] = S_W'(s_reg[i][S_W-1:HALF_W]) * S_W'(s_reg[i][HALF_W-1:0]);
            ll_next[i] = S_W'(s_reg[i][HALF_W-1:0]) * S_W'(s_reg[i][HALF_W-1:0]);
        end
        rot_next[0] = rot_diag(yy_reg, zz_reg);
        rot_next[1] = rot_diff(xy_reg, rz_reg);
        rot_next[2] = rot_sum(xz_reg, ry_reg);
        rot_next[3] = rot_sum(xy_reg, rz_reg);
        rot_next[4] = rot_diag(xx_reg, zz_reg);
        rot_next[5] = rot_diff(yz_reg, rx_reg);
        rot_next[6] = rot_diff(xz_reg, ry_reg);
        rot_next[7] = rot_sum(yz_reg, rx_reg);
        rot_next[8] = rot_diag(xx_reg, yy_reg);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sq_next[i] = (SQ_W'(hh_reg[i]) << S_W)
                       + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                       + SQ_W'(ll_reg[i]);
        end
        for (int e = 0; e < NUM_COV; e++)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                prod_next[e][i] = PROD_W'(rot_reg[NUM_AXES*COV_ROW[e]+i])
                                * PROD_W'(rot_reg[NUM_AXES*COV_COL[e]+i]);
            end
        end
    end

    for (genvar e = 0; e < NUM_COV; e++)
    begin : g_cov
        for (genvar i = 0; i < NUM_AXES; i++)
        begin : g_axis
            gcov_term u_term (
                .clk  (clk),
                .en   (term_en),
                .prod (prod_reg[e][i]),
                .sq   (sq_reg[i]),
                .term (term_w[e][i])
            );
        end
    end

    always_comb
    begin
        for (int e = 0; e < NUM_COV; e++)
        begin
            sum01_next[e] = ACC_W'(term_w[e][0]) + ACC_W'(term_w[e][1]);
            t2_next[e]    = term_w[e][2];
            acc_next[e]   = sum01_reg[e] + ACC_W'(t2_reg[e]);
            cov_next[e]   = sat_q32(acc_reg[e]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s_reg  <= s_next;
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            xy_reg <= xy_next;
            xz_reg <= xz_next;
            yz_reg <= yz_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
        end
        if (stage_en[1])
        begin
            hh_reg  <= hh_next;
            hl_reg  <= hl_next;
            ll_reg  <= ll_next;
            rot_reg <= rot_next;
        end
        if (stage_en[2])
        begin
            sq_reg   <= sq_next;
            prod_reg <= prod_next;
        end
        if (stage_en[ST_SUM])
        begin
            sum01_reg <= sum01_next;
            t2_reg    <= t2_next;
        end
        if (stage_en[ST_ACC])
        begin
            acc_reg <= acc_next;
        end
        if (stage_en[ST_OUT])
        begin
            cov_reg <= cov_next;
        end
    end

    assign in_stall  = !stage_en[0];
    assign out_valid = v_reg[ST_OUT];
    assign cov_xx    = cov_reg[0];
    assign cov_xy    = cov_reg[1];
    assign cov_xz    = cov_reg[2];
    assign cov_yy    = cov_reg[3];
    assign cov_yz    = cov_reg[4];
    assign cov_zz    = cov_reg[5];

endmodule

[design/gcov_checker.sv]
`include "gaussian_covariance_from_scale_rot_defines.svh"

module gcov_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] cov_xx,
    input logic [63:0] cov_xy,
    input logic [63:0] cov_xz,
    input logic [63:0] cov_yy,
    input logic [63:0] cov_yz,
    input logic [63:0] cov_zz
);

    logic [6*64-1:0] cov_all;

    assign cov_all = {cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz};

    // a held output word stays valid and unchanged
    `GCOV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `GCOV_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(cov_all))

    // diagonal is a sum of squares
    `GCOV_ASSERT_NOW(a_diag_nonneg, out_valid, !cov_xx[63] && !cov_yy[63] && !cov_zz[63])

    // input backs up only behind a stalled output word
    `GCOV_ASSERT_NOW(a_stall_only_full, in_valid && in_stall, out_valid && out_stall)

endmodule

bind gaussian_covariance_from_scale_rot gcov_checker u_gcov_checker (.*);
